[rtl/separable_conv_replicate_border_macros.svh]
// Assertion macros for the block that checks itself.
`ifndef SEPARABLE_CONV_REPLICATE_BORDER_MACROS_SVH
`define SEPARABLE_CONV_REPLICATE_BORDER_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define SCRB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication checked in the cycle after the antecedent.
`define SCRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/scrb_pkg.sv]
// Package with the types, constants and helpers of the separable filter.
`timescale 1ns / 1ps
`default_nettype none
package scrb_pkg;
  localparam int MAX_COLS = 1024;
  localparam int DATA_W = 32;
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = 16;
  localparam int WID_W = 11;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_CELLS = 3;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_H0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_H1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_H2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_V0 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_V1 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_V2 = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HMUL,
    ST_VMUL,
    ST_EMIT
  } state_t;

  // Control word handed from the sequencer to the tap cells.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  function automatic logic [31:0] cut(input logic [31:0] x);
    cut = 32'($signed(x[DATA_W-1:0]));
  endfunction
endpackage
`default_nettype wire

[rtl/scrb_ram.sv]
// Generic single-port-write RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module scrb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data_r
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end
endmodule
`default_nettype wire

[rtl/scrb_tap_cell.sv]
// One tap cell: holds an operand and a partial sum, multiplies and passes on.
`timescale 1ns / 1ps
`default_nettype none
module scrb_tap_cell (
  input  wire logic                clk,
  input  wire scrb_pkg::cell_ctl_t ctl,
  input  wire logic [31:0]         load_op,
  input  wire logic [31:0]         load_coef,
  input  wire logic [31:0]         sum_in,
  output logic      [31:0]         sum_out_r
);
  import scrb_pkg::*;

  logic [31:0] op_r;
  logic [31:0] coef_r;
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_r <= load_op;
      coef_r <= load_coef;
    end
    if (ctl.shift) begin
      sum_out_r <= sum_in + 32'(op_r * coef_r);
    end
  end
endmodule
`default_nettype wire

[rtl/separable_conv_replicate_border.sv]
// Top level of the streaming 3x3 separable filter with replicated border.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_tvalid/tready   | tdata = pixel_in
//  out_    | output    | out_tvalid/tready  | tdata = out_row,out_col,out_value; tlast
//  cfg_    | input     | cfg_valid/ready    | cfg_index, cfg_data
//
// One pixel is taken per pass, only while the block is idle. A pixel in column
// 0 or 1 starts no pass. Any other pixel runs the horizontal sum through the
// chain of three tap cells (a load step, then shift steps that ripple the sum
// down the chain), then the vertical sum the same way. Rows 0 and 1 and columns
// 0 and 1 send no beat; other pixels send 1 to 9 beats, one per cycle while
// out_tready is high. Reset (rst_n low, synchronous) clears position, pixel
// history and taps, and sets width and height to 1024. A stalled output holds
// the current beat; no new pixel is taken until the last beat of the current
// one has left.
`timescale 1ns / 1ps
`default_nettype none
`include "separable_conv_replicate_border_macros.svh"
module separable_conv_replicate_border (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] pixel_in
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [15:0] out_row, [25:16] out_col, [57:26] out_value
  output logic             out_tlast,  // run_end
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import scrb_pkg::*;

  logic [WID_W-1:0] width_r;
  logic [ROW_W-1:0] height_r;
  logic [31:0] htap_r [NUM_CELLS];
  logic [31:0] vtap_r [NUM_CELLS];
  logic [31:0] hist0_r, hist1_r, hist2_r;
  logic [ROW_W-1:0] row_r, r_r;
  logic [COL_W-1:0] col_r, c_r;
  logic [ROW_W-1:0] eff_h;
  logic [WID_W-1:0] eff_w;
  state_t state_r, state_nxt;
  logic [1:0] step_r, step_nxt;
  logic [1:0] ri_r, ri_nxt, ci_r, ci_nxt;
  logic [1:0] nr, nc;
  cell_ctl_t ctl;
  logic [31:0] ops [NUM_CELLS];
  logic [31:0] coefs [NUM_CELLS];
  logic [31:0] sums [NUM_CELLS+1];
  logic [31:0] chain_out;
  logic [31:0] a1, a2;
  logic accept, last_beat;

  // Effective geometry after clamping.
  always_comb begin
    eff_w = width_r;
    if (width_r < WID_W'(3)) eff_w = WID_W'(3);
    if (width_r > WID_W'(MAX_COLS)) eff_w = WID_W'(MAX_COLS);
    eff_h = (height_r < ROW_W'(3)) ? ROW_W'(3) : height_r;
  end

  // Position of the pixel about to be taken, wrapped against the geometry.
  logic [ROW_W-1:0] pr;
  logic [COL_W-1:0] pc;
  logic [ROW_W:0] pr_inc;
  always_comb begin
    pr_inc = {1'b0, row_r};
    if ({1'b0, col_r} >= eff_w) begin
      pc = '0;
      pr_inc = pr_inc + (ROW_W+1)'(1);
    end else begin
      pc = col_r;
    end
    pr = (pr_inc >= {1'b0, eff_h}) ? '0 : pr_inc[ROW_W-1:0];
  end

  assign accept = in_tvalid && in_tready;
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_tready = (state_r == ST_IDLE);

  logic [COL_W-1:0] cc;
  assign cc = c_r - COL_W'(1);

  // The end of the chain holds the horizontal sum at the first vertical step
  // and the filtered value while beats are sent.
  assign chain_out = cut(sums[NUM_CELLS]);

  // Line buffers, read at the center column of the pass. They are written at
  // the first vertical step, after the old entries have been loaded.
  logic wr_en;
  assign wr_en = (state_r == ST_VMUL) && (step_r == 2'd0) && (c_r >= COL_W'(2));
  scrb_ram #(.WIDTH(32), .DEPTH(MAX_COLS)) u_prev (
    .clk(clk), .wr_en(wr_en), .wr_addr(cc), .wr_data(chain_out),
    .rd_addr(cc), .rd_data_r(a1));
  scrb_ram #(.WIDTH(32), .DEPTH(MAX_COLS)) u_prev2 (
    .clk(clk), .wr_en(wr_en), .wr_addr(cc), .wr_data(a1),
    .rd_addr(cc), .rd_data_r(a2));

  // Tap-cell chain: cell k multiplies operand k with coefficient k.
  always_comb begin
    if (state_r == ST_HMUL) begin
      ops[0] = hist2_r; ops[1] = hist1_r; ops[2] = hist0_r;
      for (int k = 0; k < NUM_CELLS; k++) coefs[k] = cut(htap_r[k]);
    end else begin
      ops[0] = a2; ops[1] = a1; ops[2] = chain_out;
      for (int k = 0; k < NUM_CELLS; k++) coefs[k] = cut(vtap_r[k]);
    end
  end
  assign sums[0] = '0;
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    scrb_tap_cell u_cell (
      .clk(clk), .ctl(ctl), .load_op(ops[g]), .load_coef(coefs[g]),
      .sum_in(sums[g]), .sum_out_r(sums[g+1]));
  end

  // Border replication counts.
  logic [ROW_W-1:0] rr;
  assign rr = r_r - ROW_W'(1);
  always_comb begin
    nr = 2'd1 + 2'(rr == ROW_W'(1)) + 2'(rr == eff_h - ROW_W'(2));
    nc = 2'd1 + 2'(cc == COL_W'(1)) + 2'({1'b0, cc} == eff_w - WID_W'(2));
  end
  logic [ROW_W-1:0] orow;
  logic [COL_W-1:0] ocol;
  always_comb begin
    orow = rr;
    if (rr == ROW_W'(1) && ri_r == 2'd0) orow = '0;
    else if (ri_r == nr - 2'd1 && rr == eff_h - ROW_W'(2) && nr != 2'd1 &&
             !(rr == ROW_W'(1) && nr == 2'd2)) orow = eff_h - ROW_W'(1);
    ocol = cc;
    if (cc == COL_W'(1) && ci_r == 2'd0) ocol = '0;
    else if (ci_r == nc - 2'd1 && {1'b0, cc} == eff_w - WID_W'(2) && nc != 2'd1 &&
             !(cc == COL_W'(1) && nc == 2'd2)) ocol = COL_W'(eff_w - WID_W'(1));
  end
  assign last_beat = (ri_r == nr - 2'd1) && (ci_r == nc - 2'd1);
  assign out_tvalid = (state_r == ST_EMIT);
  assign out_tdata = {6'd0, chain_out, ocol, orow};
  assign out_tlast = last_beat;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    ri_nxt = ri_r;
    ci_nxt = ci_r;
    ctl = '{load: 1'b0, shift: 1'b0};
    case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (accept) state_nxt = (pc >= COL_W'(2)) ? ST_HMUL : ST_IDLE;
      end
      ST_HMUL: begin
        // step 0 loads operands, steps 1..3 ripple the sum down the chain.
        ctl.load = (step_r == 2'd0);
        ctl.shift = (step_r != 2'd0);
        step_nxt = step_r + 1'b1;
        if (step_r == 2'd3) begin
          state_nxt = ST_VMUL;
          step_nxt = '0;
        end
      end
      ST_VMUL: begin
        // Same pattern; step 0 loads the horizontal sum from the chain end.
        ctl.load = (step_r == 2'd0);
        ctl.shift = (step_r != 2'd0);
        step_nxt = step_r + 1'b1;
        if (step_r == 2'd3) begin
          step_nxt = '0;
          ri_nxt = '0;
          ci_nxt = '0;
          state_nxt = (r_r >= ROW_W'(2)) ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_tready) begin
          if (last_beat) begin
            state_nxt = ST_IDLE;
          end else if (ci_r == nc - 2'd1) begin
            ci_nxt = '0;
            ri_nxt = ri_r + 1'b1;
          end else begin
            ci_nxt = ci_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r <= '0;
      ri_r <= '0;
      ci_r <= '0;
      width_r <= WID_W'(1024);
      height_r <= ROW_W'(1024);
      for (int k = 0; k < NUM_CELLS; k++) begin
        htap_r[k] <= '0;
        vtap_r[k] <= '0;
      end
      hist0_r <= '0;
      hist1_r <= '0;
      hist2_r <= '0;
      row_r <= '0;
      col_r <= '0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
      ri_r <= ri_nxt;
      ci_r <= ci_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WIDTH:  width_r <= cfg_data[WID_W-1:0];
          REG_HEIGHT: height_r <= cfg_data[ROW_W-1:0];
          REG_H0: htap_r[0] <= cfg_data;
          REG_H1: htap_r[1] <= cfg_data;
          REG_H2: htap_r[2] <= cfg_data;
          REG_V0: vtap_r[0] <= cfg_data;
          REG_V1: vtap_r[1] <= cfg_data;
          REG_V2: vtap_r[2] <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        // hist0_r is the pixel just taken, hist1_r and hist2_r the two before.
        hist2_r <= hist1_r;
        hist1_r <= hist0_r;
        hist0_r <= cut(in_tdata);
        if (WID_W'(pc) + WID_W'(1) >= eff_w) begin
          col_r <= '0;
          row_r <= (pr + ROW_W'(1) >= eff_h) ? '0 : pr + ROW_W'(1);
        end else begin
          col_r <= pc + COL_W'(1);
          row_r <= pr;
        end
      end
    end
  end

  // Position of the pixel in flight.
  always_ff @(posedge clk) begin
    if (accept) begin
      r_r <= pr;
      c_r <= pc;
    end
  end

  `SCRB_ASSERT_IMP(a_no_take_while_busy, state_r != ST_IDLE, !in_tready,
    "pixel taken while a pass is in flight")
  `SCRB_ASSERT_NEXT(a_hold_on_stall, out_tvalid && !out_tready, out_tvalid,
    "output beat dropped while stalled")
  `SCRB_ASSERT_IMP(a_cfg_only_idle, cfg_ready, state_r == ST_IDLE,
    "configuration taken outside idle")
endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the streaming 3x3 separable filter with replicated border.
`timescale 1ns / 1ps
`default_nettype none

// One expected output beat of the filter.
typedef struct {
  logic [15:0] row;
  logic [9:0]  col;
  logic [31:0] value;
  logic        last;
} filt_beat_t;

// Mirrors the filter's registers, pixel history and line buffers, and keeps
// the beats that are still owed by the block in arrival order.
class filt_scoreboard;
  logic [10:0] width_reg;
  logic [15:0] height_reg;
  logic [31:0] htap[3];
  logic [31:0] vtap[3];
  logic [31:0] hist1, hist0;
  logic [31:0] line_prev[1024];
  logic [31:0] line_prev2[1024];
  int unsigned row_pos, col_pos;
  filt_beat_t  owed[$];
  int          mismatches;

  function new();
    width_reg = 11'd1024;
    height_reg = 16'd1024;
    foreach (htap[i]) htap[i] = '0;
    foreach (vtap[i]) vtap[i] = '0;
    hist1 = '0;
    hist0 = '0;
    row_pos = 0;
    col_pos = 0;
    mismatches = 0;
  endfunction

  function void note_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      scrb_pkg::REG_WIDTH:  width_reg = data[10:0];
      scrb_pkg::REG_HEIGHT: height_reg = data[15:0];
      scrb_pkg::REG_H0:     htap[0] = data;
      scrb_pkg::REG_H1:     htap[1] = data;
      scrb_pkg::REG_H2:     htap[2] = data;
      scrb_pkg::REG_V0:     vtap[0] = data;
      scrb_pkg::REG_V1:     vtap[1] = data;
      scrb_pkg::REG_V2:     vtap[2] = data;
      default: ;
    endcase
  endfunction

  // Works out every beat one accepted pixel causes.
  function void note_pixel(logic [31:0] px);
    int unsigned w, h, r, c, cc, rr;
    logic [31:0] hsum, above2, above1, val;
    int unsigned rows[$], cols[$];
    filt_beat_t b;
    w = (width_reg < 3) ? 3 : (width_reg > 1024 ? 1024 : width_reg);
    h = (height_reg < 3) ? 3 : height_reg;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    r = row_pos;
    c = col_pos;
    if (c >= 2) begin
      cc = c - 1;
      hsum = hist1 * htap[0] + hist0 * htap[1] + px * htap[2];
      above2 = line_prev2[cc];
      above1 = line_prev[cc];
      line_prev2[cc] = above1;
      line_prev[cc] = hsum;
      if (r >= 2) begin
        rr = r - 1;
        val = above2 * vtap[0] + above1 * vtap[1] + hsum * vtap[2];
        if (rr == 1) rows.push_back(0);
        rows.push_back(rr);
        if (rr == h - 2) rows.push_back(h - 1);
        if (cc == 1) cols.push_back(0);
        cols.push_back(cc);
        if (cc == w - 2) cols.push_back(w - 1);
        foreach (rows[i]) begin
          foreach (cols[j]) begin
            b.row = rows[i][15:0];
            b.col = cols[j][9:0];
            b.value = val;
            b.last = (i == rows.size() - 1) && (j == cols.size() - 1);
            owed.push_back(b);
          end
        end
      end
    end
    hist1 = hist0;
    hist0 = px;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  function void check_beat(logic [63:0] data, logic last);
    filt_beat_t e;
    if (owed.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected beat: row %0d col %0d value %h last %b",
                 data[15:0], data[25:16], data[57:26], last);
      return;
    end
    e = owed.pop_front();
    if (data[15:0] !== e.row || data[25:16] !== e.col || data[57:26] !== e.value ||
        data[63:58] !== 6'd0 || last !== e.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("beat mismatch: exp row %0d col %0d value %h last %b, %s",
                 e.row, e.col, e.value, e.last,
                 $sformatf("got row %0d col %0d value %h last %b",
                           data[15:0], data[25:16], data[57:26], last));
    end
  endfunction
endclass

module tb;
  import scrb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  // Long enough to cover any pixel that is still in flight without a result.
  localparam int DRAIN_CYCLES = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Idling on both sides is switched off for the closing stretch of the run.
  logic        idling = 1'b1;
  int          stall_left = 0;
  int unsigned cycles = 0;
  int unsigned pause_frame;
  filt_scoreboard sb;

  separable_conv_replicate_border i_dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #10 clk = ~clk;

  // Every result beat is checked at the edge where it is taken.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_beat(out_tdata, out_tlast);
  end

  // The receiver stalls in random bursts while idling is on.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 14);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Valid stays high across back-to-back writes; set_frame drops it after the last.
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.note_reg(idx, data);
  endtask

  // Waits until every owed beat has left, then lets a pass in flight settle.
  task automatic wait_drained();
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame(logic [31:0] w, logic [31:0] h, logic [31:0] h0,
                           logic [31:0] h1, logic [31:0] h2, logic [31:0] v0,
                           logic [31:0] v1, logic [31:0] v2);
    in_tvalid <= 1'b0;
    wait_drained();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_H0, h0);
    write_reg(REG_H1, h1);
    write_reg(REG_H2, h2);
    write_reg(REG_V0, v0);
    write_reg(REG_V1, v1);
    write_reg(REG_V2, v2);
    cfg_valid <= 1'b0;
  endtask

  // Sends one pixel beat; valid stays high into the next beat unless a gap follows.
  task automatic send_pixel(logic [31:0] px);
    if (idling && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= px;
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(px);
  endtask

  function automatic logic [31:0] rand_tap();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      default: return 32'($signed($urandom_range(0, 8)) - 4);
    endcase
  endfunction

  function automatic logic [31:0] rand_pixel();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned w, h, sent, frame;
    logic [31:0] corner[9];
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A 3x3 frame has one interior point, so that one pixel causes all nine
    // beats. The pixels include the extremes of the field.
    corner = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h1,
               32'h5555_5555, 32'haaaa_aaaa, 32'h8000_0001, 32'h7fff_fffe};
    set_frame(3, 3, 1, 2, 3, 1, 1, 1);
    foreach (corner[i]) send_pixel(corner[i]);

    // Width and height below their floor are raised to 3; the taps include their extremes.
    set_frame(0, 2, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
              32'h7fff_ffff, 32'h8000_0000, 32'h1);
    foreach (corner[i]) send_pixel(corner[8 - i]);

    // Random small frames, always run to their end so that the next geometry
    // starts at the top left corner.
    sent = 0;
    frame = 0;
    pause_frame = $urandom_range(0, 3);
    while (sent < 65) begin
      w = $urandom_range(3, 7);
      h = $urandom_range(3, 6);
      set_frame(w, h, rand_tap(), rand_tap(), rand_tap(), rand_tap(), rand_tap(),
                rand_tap());
      for (int unsigned p = 0; p < w * h; p++) begin
        // Hold the sender back once until the block has nothing left to send.
        if (frame == pause_frame && p == w * h / 2) begin
          in_tvalid <= 1'b0;
          do @(posedge clk); while (sb.owed.size() != 0);
        end
        send_pixel(rand_pixel());
      end
      sent += w * h;
      frame++;
    end

    // Closing stretch without idling, in the tallest frame the block allows.
    set_frame(5, 65535, rand_tap(), rand_tap(), rand_tap(), rand_tap(), rand_tap(),
              rand_tap());
    idling <= 1'b0;
    for (int unsigned p = 0; p < 45; p++) send_pixel(rand_pixel());
    in_tvalid <= 1'b0;

    wait_drained();
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

`default_nettype wire
